/* rtl/tvs_pkg.sv */
package tvs_pkg;

	localparam int MAX_WIDTH_DEF  = 4096;
	localparam int MAX_HEIGHT_DEF = 512;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	localparam logic [CFG_IDX_W-1:0] REG_SPAN_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPAN_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SHADE_MODE  = 2'd2;

	// quotient bits kept by the divider, larger quotients saturate
	localparam int QBITS = 10;

	// r, g, b, a, red-branch select, zero region, zero alpha
	localparam int PAY_W = 35;

	typedef struct packed {
		logic [12:0] span_width;
		logic [9:0]  span_height;
		logic        shade_mode;
	} cfg_t;

	// exact floor(q / 3) for q below 1024
	function automatic logic [QBITS-1:0] div3(input logic [QBITS-1:0] q);
		logic [2*QBITS:0] prod;
		prod = (2*QBITS+1)'(q) * (2*QBITS+1)'(683);
		return prod[2*QBITS:QBITS+1];
	endfunction

endpackage

/* rtl/tvs_cfg.sv */
module tvs_cfg import tvs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg      = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.span_width  <= 13'd1;
			cfg_q.span_height <= 10'd1;
			cfg_q.shade_mode  <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SPAN_WIDTH:  cfg_q.span_width  <= cfg_data;
				REG_SPAN_HEIGHT: cfg_q.span_height <= cfg_data[9:0];
				REG_SHADE_MODE:  cfg_q.shade_mode  <= cfg_data[0];
				default: ;
			endcase
		end
	end

endmodule

/* rtl/tvs_div.sv */
module tvs_div import tvs_pkg::*; #(
	parameter int NW = 33,
	parameter int AW = 22,
	parameter int PW = PAY_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_vld,
	input  logic [NW-1:0]    num_c,
	input  logic [NW-1:0]    num_g,
	input  logic [AW-1:0]    dvs,
	input  logic [PW-1:0]    pay_in,
	output logic             out_vld,
	output logic [QBITS-1:0] q_c,
	output logic [QBITS-1:0] q_g,
	output logic [PW-1:0]    pay_out
);

	localparam int DW = ((NW > AW + QBITS) ? NW : AW + QBITS) + 1;

	logic [NW-1:0]    rc  [0:QBITS-1];
	logic [NW-1:0]    rg  [0:QBITS-1];
	logic [AW-1:0]    d   [0:QBITS-1];
	logic [QBITS-1:0] qc  [0:QBITS];
	logic [QBITS-1:0] qg  [0:QBITS];
	logic             oc  [0:QBITS];
	logic             og  [0:QBITS];
	logic [PW-1:0]    pay [0:QBITS];
	logic             v   [0:QBITS];

	logic [DW-1:0] lim;

	// overflow stage: quotient of 2**QBITS or more saturates
	assign lim = DW'(dvs) << QBITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v[0] <= 1'b0;
		end else if (en) begin
			v[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rc[0]  <= num_c;
			rg[0]  <= num_g;
			d[0]   <= dvs;
			oc[0]  <= DW'(num_c) >= lim;
			og[0]  <= DW'(num_g) >= lim;
			qc[0]  <= '0;
			qg[0]  <= '0;
			pay[0] <= pay_in;
		end
	end

	// one restoring step per stage, msb first
	for (genvar k = 1; k <= QBITS; k++) begin : g_step
		localparam int SH = QBITS - k;

		logic [DW-1:0]    sub_w;
		logic             ge_c;
		logic             ge_g;
		logic [QBITS-1:0] bit_w;

		always_comb begin
			sub_w = DW'(d[k-1]) << SH;
			ge_c  = DW'(rc[k-1]) >= sub_w;
			ge_g  = DW'(rg[k-1]) >= sub_w;
			bit_w = {{(QBITS-1){1'b0}}, 1'b1} << SH;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v[k] <= 1'b0;
			end else if (en) begin
				v[k] <= v[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				qc[k]  <= ge_c ? (qc[k-1] | bit_w) : qc[k-1];
				qg[k]  <= ge_g ? (qg[k-1] | bit_w) : qg[k-1];
				oc[k]  <= oc[k-1];
				og[k]  <= og[k-1];
				pay[k] <= pay[k-1];
			end
		end

		if (k < QBITS) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rc[k] <= ge_c ? NW'(DW'(rc[k-1]) - sub_w) : rc[k-1];
					rg[k] <= ge_g ? NW'(DW'(rg[k-1]) - sub_w) : rg[k-1];
					d[k]  <= d[k-1];
				end
			end
		end
	end

	assign out_vld = v[QBITS];
	assign q_c     = oc[QBITS] ? '1 : qc[QBITS];
	assign q_g     = og[QBITS] ? '1 : qg[QBITS];
	assign pay_out = pay[QBITS];

endmodule

/* rtl/text_vertical_shade.sv */
// a pixel accepted at the input passes through fourteen register stages to the outputs:
// position and area, products, overflow, ten divide steps, output
// throughput: one pixel per cycle while the output is not stalled, set by the fully pipelined one-bit-per-stage divider
// a stalled output freezes the whole pipeline, nothing is dropped or repeated
// reset: asynchronous, clears all valid bits and sets width 1, height 1, mode 0
module text_vertical_shade import tvs_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            red_in,
	input  logic [7:0]            green_in,
	input  logic [7:0]            blue_in,
	input  logic [7:0]            alpha_in,
	input  logic [11:0]           column,
	input  logic [8:0]            row,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            red_out,
	output logic [7:0]            green_out,
	output logic [7:0]            blue_out,
	output logic [7:0]            alpha_out
);

	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int HW  = $clog2(MAX_HEIGHT + 1);
	localparam int CWW = (WW > 13) ? WW : 13;
	localparam int CHW = (HW > 10) ? HW : 10;
	localparam int PW  = 9 + WW + 1;
	localparam int AW  = WW + HW;
	localparam int NW  = PW + 9;

	cfg_t cfg;
	logic en;

	tvs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// whole pipeline advances together unless the output beat is stuck
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// stage 1: clamp region, position and area
	logic [CWW-1:0] w_ext;
	logic [CHW-1:0] h_ext;
	logic [WW-1:0]  w_c;
	logic [HW-1:0]  h_c;

	always_comb begin
		w_ext = CWW'(cfg.span_width);
		h_ext = CHW'(cfg.span_height);
		w_c   = (w_ext > CWW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(w_ext);
		h_c   = (h_ext > CHW'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(h_ext);
	end

	logic          vld_s1;
	logic [PW-1:0] pos_s1;
	logic [AW-1:0] area_s1;
	logic [7:0]    r_s1, g_s1, b_s1, a_s1, vsel_s1;
	logic          sel_s1, zr_s1, az_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s1  <= PW'(row) * PW'(w_c) + PW'(column);
			area_s1 <= AW'(w_c) * AW'(h_c);
			r_s1    <= red_in;
			g_s1    <= green_in;
			b_s1    <= blue_in;
			a_s1    <= alpha_in;
			sel_s1  <= red_in >= blue_in;
			vsel_s1 <= (red_in >= blue_in) ? red_in : blue_in;
			zr_s1   <= (cfg.span_width == '0) || (cfg.span_height == '0);
			az_s1   <= alpha_in == 8'd0;
		end
	end

	// stage 2: numerators, doubled for the strong red branch
	logic          dbl;
	logic [NW-1:0] nc_w, ng_w;

	always_comb begin
		dbl  = !cfg.shade_mode && sel_s1;
		nc_w = NW'(vsel_s1) * NW'(pos_s1);
		ng_w = NW'(g_s1) * NW'(pos_s1);
	end

	logic             vld_s2;
	logic [NW-1:0]    nc_s2, ng_s2;
	logic [AW-1:0]    area_s2;
	logic [PAY_W-1:0] pay_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nc_s2   <= dbl ? (nc_w << 1) : nc_w;
			ng_s2   <= dbl ? (ng_w << 1) : ng_w;
			area_s2 <= area_s1;
			pay_s2  <= {r_s1, g_s1, b_s1, a_s1, sel_s1, zr_s1, az_s1};
		end
	end

	logic             vld_d;
	logic [QBITS-1:0] qc_d, qg_d;
	logic [PAY_W-1:0] pay_d;

	tvs_div #(
		.NW (NW),
		.AW (AW),
		.PW (PAY_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s2),
		.num_c   (nc_s2),
		.num_g   (ng_s2),
		.dvs     (area_s2),
		.pay_in  (pay_s2),
		.out_vld (vld_d),
		.q_c     (qc_d),
		.q_g     (qg_d),
		.pay_out (pay_d)
	);

	// output stage: final divide by 3, 2 or 4 and saturating subtract
	function automatic logic [7:0] shade(input logic [7:0] v, input logic [QBITS-1:0] cut);
		return (cut >= QBITS'(v)) ? 8'd0 : 8'(QBITS'(v) - cut);
	endfunction

	logic [7:0]       r_d, g_d, b_d, a_d;
	logic             sel_d, zr_d, az_d;
	logic [QBITS-1:0] cc, cg;
	logic [7:0]       r_n, g_n, b_n;

	always_comb begin
		{r_d, g_d, b_d, a_d, sel_d, zr_d, az_d} = pay_d;
		if (cfg.shade_mode) begin
			cc = qc_d >> 2;
			cg = qg_d >> 2;
		end else if (sel_d) begin
			cc = div3(qc_d);
			cg = div3(qg_d);
		end else begin
			cc = qc_d >> 1;
			cg = qg_d >> 1;
		end
		priority if (zr_d) begin
			r_n = r_d;
			g_n = g_d;
			b_n = b_d;
		end else if (az_d) begin
			r_n = 8'd0;
			g_n = 8'd0;
			b_n = 8'd0;
		end else if (sel_d) begin
			r_n = shade(r_d, cc);
			g_n = shade(g_d, cg);
			b_n = b_d;
		end else begin
			r_n = r_d;
			g_n = shade(g_d, cg);
			b_n = shade(b_d, cc);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= vld_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			red_out   <= r_n;
			green_out <= g_n;
			blue_out  <= b_n;
			alpha_out <= a_d;
		end
	end

endmodule

/* bench/text_vertical_shade_tb.sv */
module text_vertical_shade_tb;
	import tvs_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int LIMIT_CYCLES = 200000;
	localparam int HOLD_CYCLES  = 300;
	localparam int TAIL_CYCLES  = 30;

	typedef struct packed {
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic [11:0] column;
		logic [8:0]  row;
	} pixel_in_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} pixel_out_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [7:0]            red_in = '0;
	logic [7:0]            green_in = '0;
	logic [7:0]            blue_in = '0;
	logic [7:0]            alpha_in = '0;
	logic [11:0]           column = '0;
	logic [8:0]            row = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [7:0]            red_out;
	logic [7:0]            green_out;
	logic [7:0]            blue_out;
	logic [7:0]            alpha_out;

	// shadow copy of the region registers
	logic [12:0] cur_width = 13'd1;
	logic [9:0]  cur_height = 10'd1;
	logic        cur_mode = 1'b0;

	pixel_in_t  pend_pix_q[$];
	pixel_out_t shaded_q[$];

	int send_idle = 13;
	int recv_idle = 72;
	int errors = 0;
	int n_accepted = 0;
	int n_results = 0;
	int n_writes = 0;
	int n_settings = 0;
	int stall_cycles = 0;
	int cycle_cnt = 0;

	logic hold_req = 1'b0;
	logic hold_done = 1'b0;
	int   hold_left = 0;

	text_vertical_shade dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.red_in    (red_in),
		.green_in  (green_in),
		.blue_in   (blue_in),
		.alpha_in  (alpha_in),
		.column    (column),
		.row       (row),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out),
		.alpha_out (alpha_out)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// channel minus its gradient cut, floored at zero
	function automatic logic [7:0] dim(input longint unsigned v, input longint unsigned num,
			input longint unsigned area2, input longint unsigned div);
		longint unsigned cut;
		cut = v * num / area2 / div;
		return (cut >= v) ? 8'd0 : 8'(v - cut);
	endfunction

	function automatic pixel_out_t shade_pixel(input pixel_in_t p);
		longint unsigned w;
		longint unsigned h;
		longint unsigned area2;
		longint unsigned pos;
		pixel_out_t o;
		w = cur_width;
		h = cur_height;
		if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
		if (h > MAX_HEIGHT_DEF) h = MAX_HEIGHT_DEF;
		o.red = p.red;
		o.green = p.green;
		o.blue = p.blue;
		o.alpha = p.alpha;
		if (w != 0 && h != 0) begin
			if (p.alpha == 8'd0) begin
				o.red = 8'd0;
				o.green = 8'd0;
				o.blue = 8'd0;
			end else begin
				area2 = w * h * 2;
				pos = (longint'(p.row) * w + longint'(p.column)) * 2;
				if (!cur_mode) begin
					if (p.red >= p.blue) begin
						o.red = dim(p.red, pos * 2, area2, 3);
						o.green = dim(p.green, pos * 2, area2, 3);
					end else begin
						o.blue = dim(p.blue, pos, area2, 2);
						o.green = dim(p.green, pos, area2, 2);
					end
				end else begin
					if (p.red >= p.blue) o.red = dim(p.red, pos, area2, 4);
					else o.blue = dim(p.blue, pos, area2, 4);
					o.green = dim(p.green, pos, area2, 4);
				end
			end
		end
		return o;
	endfunction

	// pixel driver
	always @(posedge clk) begin : drv
		pixel_in_t p;
		if (arst_n) begin
			if (in_valid && !in_ready) stall_cycles++;
			if (in_valid && in_ready) begin
				p.red = red_in;
				p.green = green_in;
				p.blue = blue_in;
				p.alpha = alpha_in;
				p.column = column;
				p.row = row;
				shaded_q.insert(shaded_q.size(), shade_pixel(p));
				n_accepted++;
			end
			if (!in_valid || in_ready) begin
				if (pend_pix_q.size() != 0 && $urandom_range(99, 0) >= send_idle) begin
					p = pend_pix_q.pop_front();
					red_in <= p.red;
					green_in <= p.green;
					blue_in <= p.blue;
					alpha_in <= p.alpha;
					column <= p.column;
					row <= p.row;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin : mon
		pixel_out_t want;
		logic [7:0] want_v[4];
		logic [7:0] got_v[4];
		string      names[4];
		names = '{"red", "green", "blue", "alpha"};
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got_v = '{red_out, green_out, blue_out, alpha_out};
				if (shaded_q.size() == 0) begin
					$display("%0t: beat with nothing expected, expected none actual %h %h %h %h",
						$time, red_out, green_out, blue_out, alpha_out);
					errors++;
				end else begin
					want = shaded_q.pop_front();
					want_v = '{want.red, want.green, want.blue, want.alpha};
					for (int i = 0; i < 4; i++) begin
						if (got_v[i] !== want_v[i]) begin
							$display("%0t: %s mismatch, expected %h actual %h",
								$time, names[i], want_v[i], got_v[i]);
							errors++;
						end
					end
					n_results++;
				end
			end
			out_ready <= (hold_left == 0) && ($urandom_range(99, 0) >= recv_idle);
		end
	end

	// long output hold-off, fired once
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_done) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	initial begin
		while (cycle_cnt < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_SPAN_WIDTH: cur_width = val;
			REG_SPAN_HEIGHT: cur_height = val[9:0];
			REG_SHADE_MODE: cur_mode = val[0];
			default: ;
		endcase
		n_writes++;
	endtask

	// junk in the unused upper bits and on the unused index must be ignored
	task automatic set_region(input int w, input int h, input int m);
		cfg_write(REG_UNUSED, 13'($urandom));
		cfg_write(REG_SPAN_WIDTH, 13'(w));
		cfg_write(REG_SPAN_HEIGHT, {3'($urandom), 10'(h)});
		cfg_write(REG_SHADE_MODE, {12'($urandom), 1'(m)});
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	task automatic push_pix(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
			input logic [7:0] a, input logic [11:0] c, input logic [8:0] rw);
		pixel_in_t p;
		p.red = r;
		p.green = g;
		p.blue = b;
		p.alpha = a;
		p.column = c;
		p.row = rw;
		pend_pix_q.insert(pend_pix_q.size(), p);
	endtask

	task automatic push_random(input int n);
		int w_eff;
		int h_eff;
		int kind;
		pixel_in_t p;
		w_eff = (cur_width > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(cur_width);
		h_eff = (cur_height > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : int'(cur_height);
		for (int i = 0; i < n; i++) begin
			kind = $urandom_range(99, 0);
			p.red = 8'($urandom);
			p.green = 8'($urandom);
			p.blue = (kind >= 8 && kind < 13) ? p.red : 8'($urandom);
			p.alpha = (kind < 8) ? 8'd0 : 8'($urandom_range(255, 1));
			if (kind >= 90 || w_eff == 0 || h_eff == 0) begin
				p.column = 12'($urandom);
				p.row = 9'($urandom);
			end else begin
				p.column = 12'($urandom_range(w_eff - 1, 0));
				p.row = 9'($urandom_range(h_eff - 1, 0));
			end
			pend_pix_q.insert(pend_pix_q.size(), p);
		end
	endtask

	task automatic drain;
		while (pend_pix_q.size() != 0 || in_valid || shaded_q.size() != 0) @(posedge clk);
	endtask

	initial begin : main
		int w;
		int h;
		int m;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset region 1x1, strong shade
		push_pix(8'd0, 8'd0, 8'd0, 8'd0, 12'd0, 9'd0);
		push_pix(8'd255, 8'd255, 8'd255, 8'd255, 12'd0, 9'd0);
		push_pix(8'd200, 8'd100, 8'd50, 8'd0, 12'd3, 9'd4);
		push_pix(8'd10, 8'd20, 8'd30, 8'd255, 12'd0, 9'd0);
		push_pix(8'd255, 8'd255, 8'd255, 8'd1, 12'd4095, 9'd511);
		push_pix(8'd0, 8'd255, 8'd255, 8'd128, 12'd1, 9'd0);
		push_pix(8'd128, 8'd0, 8'd128, 8'd7, 12'd0, 9'd0);
		drain();

		set_region(4096, 512, 0);
		push_pix(8'd255, 8'd255, 8'd0, 8'd255, 12'd4095, 9'd511);
		push_pix(8'd0, 8'd255, 8'd255, 8'd255, 12'd4095, 9'd511);
		push_pix(8'd255, 8'd128, 8'd255, 8'd255, 12'd2048, 9'd256);
		push_pix(8'd1, 8'd1, 8'd1, 8'd1, 12'd0, 9'd0);
		push_pix(8'd255, 8'd0, 8'd254, 8'd200, 12'd0, 9'd511);
		drain();

		set_region(4096, 512, 1);
		push_pix(8'd255, 8'd255, 8'd0, 8'd255, 12'd4095, 9'd511);
		push_pix(8'd0, 8'd255, 8'd255, 8'd255, 12'd4095, 9'd511);
		push_pix(8'd100, 8'd100, 8'd100, 8'd0, 12'd4095, 9'd511);
		drain();

		// zero region leaves every channel untouched
		set_region(0, 5, 0);
		push_pix(8'd10, 8'd20, 8'd30, 8'd0, 12'd3, 9'd3);
		push_pix(8'd255, 8'd255, 8'd255, 8'd255, 12'd4095, 9'd511);
		drain();

		for (int ph = 0; ph < 12; ph++) begin
			case (ph)
				0: begin w = 4096; h = 512; m = 0; end
				2: begin w = 8191; h = 1023; m = 1; end
				4: begin w = 0; h = 5; m = 0; end
				5: begin w = 7; h = 0; m = 1; end
				7: begin w = 1; h = 1; m = 1; end
				10: begin w = 1; h = 512; m = 0; end
				default: begin
					w = ($urandom_range(3, 0) == 0) ? $urandom_range(8191, 0) : $urandom_range(80, 1);
					h = ($urandom_range(3, 0) == 0) ? $urandom_range(1023, 0) : $urandom_range(40, 1);
					m = $urandom_range(1, 0);
				end
			endcase
			if (ph < 4) begin
				send_idle = 13;
				recv_idle = 72;
			end else if (ph < 8) begin
				send_idle = 72;
				recv_idle = 13;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			set_region(w, h, m);
			push_random(150);
			if (ph == 9) hold_req <= 1'b1;
			drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("shaded %0d pixels (%0d results) over %0d region settings, %0d register writes",
			n_accepted, n_results, n_settings, n_writes);
		$display("input held back for %0d cycles by output back-pressure", stall_cycles);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule

/* text_vertical_shade.f */
rtl/tvs_pkg.sv
rtl/tvs_cfg.sv
rtl/tvs_div.sv
rtl/text_vertical_shade.sv
bench/text_vertical_shade_tb.sv
